// ----- rtl/mbet_pkg.sv -----
// Shared types, constants and helpers for the escape-time pixel evaluator.
package mbet_pkg;

  localparam int MAX_ROUNDS = 256;
  localparam int RND_W      = $clog2(MAX_ROUNDS + 1);
  localparam int Q_W        = 32;
  localparam int Q_FRAC     = 28;
  localparam int OPND_W     = Q_W + 1;
  localparam int PROD_W     = 64;
  localparam int CSUM_W     = 44;
  localparam int NRE_W      = 36;
  localparam int NIM_W      = 38;
  localparam int CFG_IDX_W  = 2;
  localparam int ITER_W     = 8;

  localparam logic [PROD_W-1:0] ESC_BOUND = 64'd4 << (2 * Q_FRAC);

  localparam logic signed [Q_W-1:0] ORIGIN_RE_RST = 32'shE000_0000;
  localparam logic signed [Q_W-1:0] ORIGIN_IM_RST = 32'shE800_0000;
  localparam logic signed [Q_W-1:0] STEP_RE_RST   = 32'sh000C_0000;
  localparam logic signed [Q_W-1:0] STEP_IM_RST   = 32'sh000C_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN_RE = 2'd0,
    CFG_ORIGIN_IM = 2'd1,
    CFG_STEP_RE   = 2'd2,
    CFG_STEP_IM   = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CRE,
    ST_CIM,
    ST_CFIN,
    ST_XY,
    ST_RR,
    ST_II
  } state_t;

  typedef struct packed {
    logic signed [Q_W-1:0] origin_real;
    logic signed [Q_W-1:0] origin_imag;
    logic signed [Q_W-1:0] step_real;
    logic signed [Q_W-1:0] step_imag;
  } cfg_t;

  typedef struct packed {
    logic [9:0] pixel_col;
    logic [9:0] pixel_row;
  } pix_in_t;

  typedef struct packed {
    logic [9:0]        out_col;
    logic [9:0]        out_row;
    logic              escaped;
    logic [ITER_W-1:0] iter_count;
  } pix_out_t;

  // Clamp origin + index*step to the Q4.28 range.
  function automatic logic signed [Q_W-1:0] sat_q(input logic signed [CSUM_W-1:0] v);
    logic [CSUM_W-Q_W:0] top;
    top = v[CSUM_W-1:Q_W-1];
    if ((&top) || !(|top)) return v[Q_W-1:0];
    else if (v[CSUM_W-1])  return {1'b1, {(Q_W-1){1'b0}}};
    else                   return {1'b0, {(Q_W-1){1'b1}}};
  endfunction

  function automatic logic [ITER_W-1:0] sat_iter(input logic [RND_W-1:0] r);
    if (int'(r) > 255) return {ITER_W{1'b1}};
    else               return ITER_W'(r);
  endfunction

endpackage

// ----- rtl/mbet_cfg.sv -----
// Configuration register bank: image origin and per-pixel steps.
module mbet_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mbet_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mbet_pkg::Q_W-1:0]          cfg_data,
  output mbet_pkg::cfg_t                    regs
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.origin_real <= mbet_pkg::ORIGIN_RE_RST;
      regs.origin_imag <= mbet_pkg::ORIGIN_IM_RST;
      regs.step_real   <= mbet_pkg::STEP_RE_RST;
      regs.step_imag   <= mbet_pkg::STEP_IM_RST;
    end else if (cfg_valid) begin
      unique case (mbet_pkg::cfg_idx_e'(cfg_index))
        mbet_pkg::CFG_ORIGIN_RE: regs.origin_real <= cfg_data;
        mbet_pkg::CFG_ORIGIN_IM: regs.origin_imag <= cfg_data;
        mbet_pkg::CFG_STEP_RE:   regs.step_real   <= cfg_data;
        mbet_pkg::CFG_STEP_IM:   regs.step_imag   <= cfg_data;
      endcase
    end
  end

endmodule

// ----- rtl/mbet_mul.sv -----
// Shared signed multiplier with a registered product.
module mbet_mul (
  input  logic                                clk,
  input  logic signed [mbet_pkg::OPND_W-1:0]  a,
  input  logic signed [mbet_pkg::OPND_W-1:0]  b,
  output logic signed [mbet_pkg::PROD_W-1:0]  prod
);

  logic signed [2*mbet_pkg::OPND_W-1:0] full;

  assign full = a * b;

  // Operands stay within 32 bits of magnitude, so the low 64 bits are exact.
  always_ff @(posedge clk) begin
    prod <= full[mbet_pkg::PROD_W-1:0];
  end

endmodule

// ----- rtl/mandelbrot_escape_time_pixel.sv -----
// Escape-time evaluator for one pixel, built around one shared multiplier.
// Each round takes three multiplies; at most MAX_ROUNDS rounds are evaluated per pixel,
// and a round whose new point overflows the Q4.28 range ends the pixel early.
// A new pixel is taken only once the last one is done; busy drops in the cycle done pulses.
// Reset: rst clears the sequencer and done, and loads the default view.
module mandelbrot_escape_time_pixel (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  mbet_pkg::pix_in_t                 req,
  output logic                              done,
  output mbet_pkg::pix_out_t                rsp,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mbet_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mbet_pkg::Q_W-1:0]          cfg_data
);

  localparam int QW = mbet_pkg::Q_W;
  localparam int QF = mbet_pkg::Q_FRAC;
  localparam int OW = mbet_pkg::OPND_W;
  localparam int CW = mbet_pkg::CSUM_W;
  localparam int RW = mbet_pkg::NRE_W;
  localparam int IW = mbet_pkg::NIM_W;

  mbet_pkg::cfg_t    regs;
  mbet_pkg::state_t  state, state_next;
  mbet_pkg::pix_in_t pix;

  logic signed [OW-1:0]                    mul_a, mul_b;
  logic signed [mbet_pkg::PROD_W-1:0]      prod;
  logic signed [QW-1:0]                    cre, cim, re, im;
  logic [mbet_pkg::PROD_W-1:0]             sq_re;
  logic signed [RW-1:0]                    nre_w;
  logic signed [IW-1:0]                    nim_w;
  logic [mbet_pkg::RND_W-1:0]              rnd;
  logic                                    first;
  logic                                    fin, fin_esc;

  logic [mbet_pkg::PROD_W-1:0]             sq_im_src;
  logic [mbet_pkg::PROD_W-1:0]             mag;
  logic                                    esc_mag, last_rnd, ovf;
  logic signed [RW-1:0]                    nre_calc;
  logic signed [IW-1:0]                    nim_calc;
  logic signed [CW-1:0]                    csum_re, csum_im;

  mbet_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs)
  );

  mbet_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // Squares are non-negative and at most 2^62, so their sum cannot wrap.
  assign sq_im_src = first ? '0 : prod;
  assign mag       = sq_re + prod;
  assign esc_mag   = !first && (mag > mbet_pkg::ESC_BOUND);
  assign last_rnd  = rnd == mbet_pkg::RND_W'(mbet_pkg::MAX_ROUNDS - 1);
  assign ovf       = !((&nre_w[RW-1:QW-1]) || !(|nre_w[RW-1:QW-1])) ||
                     !((&nim_w[IW-1:QW-1]) || !(|nim_w[IW-1:QW-1]));

  assign nre_calc = $signed({1'b0, sq_re[62:QF]}) - $signed({1'b0, sq_im_src[62:QF]}) +
                    RW'(cre);
  assign nim_calc = $signed(prod[63:QF-1]) + IW'(cim);
  assign csum_re  = CW'(regs.origin_real) + $signed(prod[CW-1:0]);
  assign csum_im  = CW'(regs.origin_imag) + $signed(prod[CW-1:0]);

  always_ff @(posedge clk) begin
    if (rst) state <= mbet_pkg::ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    mul_a      = '0;
    mul_b      = '0;
    fin        = 1'b0;
    fin_esc    = 1'b0;
    busy       = state != mbet_pkg::ST_IDLE;
    unique case (state)
      mbet_pkg::ST_IDLE: begin
        if (start) state_next = mbet_pkg::ST_CRE;
      end
      mbet_pkg::ST_CRE: begin
        mul_a      = OW'(pix.pixel_col);
        mul_b      = OW'(regs.step_real);
        state_next = mbet_pkg::ST_CIM;
      end
      mbet_pkg::ST_CIM: begin
        mul_a      = OW'(pix.pixel_row);
        mul_b      = OW'(regs.step_imag);
        state_next = mbet_pkg::ST_CFIN;
      end
      mbet_pkg::ST_CFIN: begin
        state_next = mbet_pkg::ST_XY;
      end
      mbet_pkg::ST_XY: begin
        // Close out the previous round's magnitude test, then open the next one.
        mul_a = OW'(re);
        mul_b = OW'(im);
        if (!first && (esc_mag || last_rnd)) begin
          fin        = 1'b1;
          fin_esc    = esc_mag;
          state_next = mbet_pkg::ST_IDLE;
        end else begin
          state_next = mbet_pkg::ST_RR;
        end
      end
      mbet_pkg::ST_RR: begin
        mul_a      = OW'($signed(nre_w[QW-1:0]));
        mul_b      = OW'($signed(nre_w[QW-1:0]));
        state_next = mbet_pkg::ST_II;
      end
      mbet_pkg::ST_II: begin
        mul_a = OW'($signed(nim_w[QW-1:0]));
        mul_b = OW'($signed(nim_w[QW-1:0]));
        if (ovf) begin
          fin        = 1'b1;
          fin_esc    = 1'b1;
          state_next = mbet_pkg::ST_IDLE;
        end else begin
          state_next = mbet_pkg::ST_XY;
        end
      end
      default: state_next = mbet_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      mbet_pkg::ST_IDLE: begin
        if (start) pix <= req;
      end
      mbet_pkg::ST_CIM: begin
        cre <= mbet_pkg::sat_q(csum_re);
      end
      mbet_pkg::ST_CFIN: begin
        cim   <= mbet_pkg::sat_q(csum_im);
        re    <= '0;
        im    <= '0;
        sq_re <= '0;
        rnd   <= '0;
        first <= 1'b1;
      end
      mbet_pkg::ST_XY: begin
        if (!first) rnd <= rnd + 1'b1;
        first <= 1'b0;
        nre_w <= nre_calc;
      end
      mbet_pkg::ST_RR: begin
        nim_w <= nim_calc;
      end
      mbet_pkg::ST_II: begin
        re    <= nre_w[QW-1:0];
        im    <= nim_w[QW-1:0];
        sq_re <= prod;
      end
      default: ;
    endcase
  end

  // Result register: one strobe per pixel, the receiver takes it as it goes by.
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= fin;
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      rsp.out_col    <= pix.pixel_col;
      rsp.out_row    <= pix.pixel_row;
      rsp.escaped    <= fin_esc;
      rsp.iter_count <= fin_esc ? mbet_pkg::sat_iter(rnd) : '0;
    end
  end

endmodule
